>>> design/mide_pkg.sv
package mide_pkg;

	localparam int NUM_CH         = 6;
	localparam int LOCK_CH        = 2;
	localparam int COUNT_BITS_DEF = 16;
	localparam int THR_BITS       = 16;
	localparam int CODE_BITS      = 5;
	localparam int VAL_BITS       = 2;

	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd50;

	// event code base and reset value per channel, in channel order
	localparam logic [CODE_BITS-1:0] CH_BASE [NUM_CH] = '{
		5'd0, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16
	};
	localparam logic [VAL_BITS-1:0] CH_RESET [NUM_CH] = '{
		2'd0, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0
	};

	typedef struct packed {
		logic [1:0] ignition_raw;
		logic       door_raw;
		logic [1:0] lock_raw;
		logic [1:0] blinker_raw;
		logic [1:0] wiper_raw;
		logic       speed_raw;
	} in_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] event_code;
		logic                 last_event;
	} out_item_t;

	typedef struct packed {
		logic                 evt;
		logic [CODE_BITS-1:0] code;
	} lane_evt_t;

endpackage

>>> design/mide_lane.sv
module mide_lane #(
	parameter int                        COUNT_BITS    = mide_pkg::COUNT_BITS_DEF,
	parameter logic [mide_pkg::CODE_BITS-1:0] BASE     = '0,
	parameter logic [mide_pkg::VAL_BITS-1:0]  RESET_VAL = '0,
	parameter bit                        SUPPRESS_HIGH = 1'b0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic [mide_pkg::VAL_BITS-1:0]      raw,
	input  logic [mide_pkg::THR_BITS-1:0]      threshold,
	output mide_pkg::lane_evt_t                evt
);
	import mide_pkg::*;

	localparam int CW = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [VAL_BITS-1:0]   stable_q, cand_q, cand_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n;
	logic [CW-1:0]         thr_ext;
	logic                  change;

	assign thr_ext = CW'(threshold);

	always_comb begin
		if (raw == cand_q) begin
			cand_n = cand_q;
			if (CW'(cnt_q) < thr_ext && cnt_q != CNT_MAX)
				cnt_n = cnt_q + 1'b1;
			else
				cnt_n = cnt_q;
		end else begin
			cand_n = raw;
			cnt_n  = '0;
		end
		change = (CW'(cnt_n) >= thr_ext) && (cand_n != stable_q);
	end

	// lock "none" and code three still move the stable value but raise nothing
	assign evt = '{
		evt:  change && !(SUPPRESS_HIGH && cand_n > 2'd1),
		code: BASE + CODE_BITS'(cand_n)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= RESET_VAL;
			cand_q   <= RESET_VAL;
			cnt_q    <= '0;
		end else if (fire) begin
			cand_q <= cand_n;
			cnt_q  <= cnt_n;
			if (change)
				stable_q <= cand_n;
		end
	end

endmodule

>>> design/mide_merge.sv
module mide_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_fire,
	input  mide_pkg::lane_evt_t [mide_pkg::NUM_CH-1:0] lane_evt,
	output logic                                   busy,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output mide_pkg::out_item_t                    out_data
);
	import mide_pkg::*;

	localparam int IW = $clog2(NUM_CH);

	logic [NUM_CH-1:0]    mask_q, pick_oh;
	logic [CODE_BITS-1:0] code_q [NUM_CH];
	logic [IW-1:0]        pick;
	logic                 move, out_valid_q;
	out_item_t            out_data_q;

	// lowest pending channel goes first
	always_comb begin
		pick = '0;
		for (int i = NUM_CH - 1; i >= 0; i--)
			if (mask_q[i])
				pick = IW'(i);
		pick_oh = '0;
		pick_oh[pick] = 1'b1;
	end

	assign move = (mask_q != '0) && (!out_valid_q || !out_stall);
	assign busy = (mask_q != '0) && !(move && $onehot(mask_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				for (int i = 0; i < NUM_CH; i++)
					mask_q[i] <= lane_evt[i].evt;
			end else if (move) begin
				mask_q <= mask_q & ~pick_oh;
			end
			if (move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			for (int i = 0; i < NUM_CH; i++)
				code_q[i] <= lane_evt[i].code;
		if (move) begin
			out_data_q.event_code <= code_q[pick];
			out_data_q.last_event <= (mask_q & ~pick_oh) == '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> (mask_q == '0) || ($onehot(mask_q) && move))
		else $error("tick loaded over pending events");

	a_move_valid: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid)
		else $error("moved event not presented");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(move && $onehot(mask_q)) |=> out_data.last_event)
		else $error("final event of tick not marked last");

	a_mask_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> (mask_q & ~$past(mask_q)) == '0)
		else $error("pending mask grew without a tick");

endmodule

>>> design/multi_input_debounce_event_generator_core.sv
// channel  | dir | handshake              | payload
// in       | in  | in_valid / in_stall    | in_data (six raw readings)
// out      | out | out_valid / out_stall  | out_data (event_code, last_event)
// cfg      | in  | cfg_wr_en              | cfg_wr_data (debounce threshold)
//
// A tick transfer updates all six debounce lanes together; its events are
// queued in a pending mask and leave one per cycle while out is not stalled,
// lowest channel first. The single result port holds in stalled until the
// last event of a tick moves out; a tick with no events does not stall in.
// The output register lets the next tick be taken while a result waits.
// Reset clears lane state to its idle values and the threshold to 50.
module multi_input_debounce_event_generator_core #(
	parameter int COUNT_BITS = mide_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  mide_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output mide_pkg::out_item_t               out_data,
	input  logic                              cfg_wr_en,
	input  logic [mide_pkg::THR_BITS-1:0]     cfg_wr_data
);
	import mide_pkg::*;

	logic [THR_BITS-1:0]     threshold_q;
	logic [VAL_BITS-1:0]     raw [NUM_CH];
	lane_evt_t [NUM_CH-1:0]  lane_evt;
	logic                    in_fire, busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THRESHOLD_RESET;
		else if (cfg_wr_en)
			threshold_q <= cfg_wr_data;
	end

	assign in_stall = busy;
	assign in_fire  = in_valid && !busy;

	assign raw[0] = in_data.ignition_raw;
	assign raw[1] = {1'b0, in_data.door_raw};
	assign raw[2] = in_data.lock_raw;
	assign raw[3] = in_data.blinker_raw;
	assign raw[4] = in_data.wiper_raw;
	assign raw[5] = {1'b0, in_data.speed_raw};

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		mide_lane #(
			.COUNT_BITS    (COUNT_BITS),
			.BASE          (CH_BASE[i]),
			.RESET_VAL     (CH_RESET[i]),
			.SUPPRESS_HIGH (i == LOCK_CH)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.fire      (in_fire),
			.raw       (raw[i]),
			.threshold (threshold_q),
			.evt       (lane_evt[i])
		);
	end

	mide_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.lane_evt  (lane_evt),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
